>>> rtl/nca_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and codes for the node chain reorder assembler.
// No dependencies; every other file of the block imports this package.
package nca_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int ID_BITS     = 7;
   localparam int ADDR_BITS   = $clog2(MAX_ENTRIES);
   localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
   localparam int CSR_ADDR_BITS = 3;

   // Marker for the master of a root entry and the slave of a closing leaf.
   localparam logic signed [ID_BITS:0] ID_NONE = '1;

   // Value of the top register-port address bit that selects the root identifier register.
   localparam logic CSR_IDX_ROOT = 1'b0;

   typedef enum logic [1:0] {
      OP_REPORT = 2'd0,
      OP_INIT   = 2'd1,
      OP_READ   = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      STAT_CHAINED    = 3'd0,
      STAT_BUFFERED   = 3'd1,
      STAT_INVALID    = 3'd2,
      STAT_FULL       = 3'd3,
      STAT_READ_OK    = 3'd4,
      STAT_READ_RANGE = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROOT_WR,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_FINISH
   } seq_state_type;

   typedef struct packed {
      logic [1:0]        opcode;
      logic signed [7:0] master_id;
      logic signed [7:0] node_id;
      logic signed [7:0] slave_id;
      logic [3:0]        read_index;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [CNT_BITS-1:0]   chain_length;
      logic [CNT_BITS-1:0]   buffered_count;
      logic                  leaf_present;
      logic signed [ID_BITS:0] entry_master;
      logic [ID_BITS-1:0]    entry_node;
      logic signed [ID_BITS:0] entry_slave;
   } rsp_type;

   // One entry of the ordered chain.
   typedef struct packed {
      logic signed [ID_BITS:0] m;
      logic [ID_BITS-1:0]      n;
      logic signed [ID_BITS:0] s;
   } chain_ent_type;

   // One parked report; all of its fields are known to be non-negative.
   typedef struct packed {
      logic [ID_BITS-1:0] m;
      logic [ID_BITS-1:0] n;
      logic [ID_BITS-1:0] s;
   } pend_ent_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      chain_ent_type        data;
   } chain_wr_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      pend_ent_type         data;
   } pend_wr_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
   } mem_rd_type;

endpackage

>>> rtl/nca_chain_ram.sv
`timescale 1ns / 1ps
// Storage for the real (non-leaf) entries of the ordered chain.
// One write port, one read port with registered data. Depends on nca_pkg.
module nca_chain_ram (
   input  logic                   clock,
   input  nca_pkg::chain_wr_type  wr,
   input  nca_pkg::mem_rd_type    rd,
   output nca_pkg::chain_ent_type rd_data
);
   import nca_pkg::*;

   chain_ent_type mem_ff [MAX_ENTRIES];
   chain_ent_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // Read data holds until the next read so it can wait for the output side.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/nca_pend_ram.sv
`timescale 1ns / 1ps
// Side buffer for reports that do not yet link to the chain.
// One write port, one read port with registered data. Depends on nca_pkg.
module nca_pend_ram (
   input  logic                  clock,
   input  nca_pkg::pend_wr_type  wr,
   input  nca_pkg::mem_rd_type   rd,
   output nca_pkg::pend_ent_type rd_data
);
   import nca_pkg::*;

   pend_ent_type mem_ff [MAX_ENTRIES];
   pend_ent_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/nca_seq.sv
`timescale 1ns / 1ps
// Sequencer of the assembler: decodes a beat, appends, rescans and compacts
// the side buffer through the two RAMs, and holds the result beat. Depends on nca_pkg.
module nca_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  nca_pkg::req_type         req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output nca_pkg::rsp_type         rsp_data,
   input  logic [nca_pkg::ID_BITS-1:0] root_id,
   output nca_pkg::chain_wr_type    chain_wr,
   output nca_pkg::mem_rd_type      chain_rd,
   input  nca_pkg::chain_ent_type   chain_rd_data,
   output nca_pkg::pend_wr_type     pend_wr,
   output nca_pkg::mem_rd_type      pend_rd,
   input  nca_pkg::pend_ent_type    pend_rd_data
);
   import nca_pkg::*;

   seq_state_type       state_ff, state_in;
   logic [CNT_BITS-1:0] base_ff, base_in;        // real entries in the chain
   logic                leaf_ff, leaf_in;        // a closing leaf follows them
   chain_ent_type       real_ff, real_in;        // last real entry
   logic [CNT_BITS-1:0] pend_cnt_ff, pend_cnt_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic [2:0]          status_ff, status_in;
   logic                show_leaf_ff, show_leaf_in;
   pend_ent_type        hold_ff, hold_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic [CNT_BITS-1:0] count;
   logic                neg_field;
   logic                links_hit;
   logic                room1;
   logic                room2;
   logic                pend_full;
   logic                read_ok;
   logic                scan_hit;
   logic                out_free;
   logic                scan_done;
   logic                shift_done;
   pend_ent_type        req_ent;
   chain_ent_type       leaf_ent;
   chain_ent_type       show;
   logic [CNT_BITS-1:0] idx_next;

   assign count      = base_ff + CNT_BITS'(leaf_ff);
   assign neg_field  = req_data.master_id[7] | req_data.node_id[7] | req_data.slave_id[7];
   // The leaf's slave is negative, so a link always goes to the last real entry.
   assign links_hit  = (base_ff != '0) && (real_ff.s == req_data.node_id);
   assign room1      = base_ff < CNT_BITS'(MAX_ENTRIES);
   assign room2      = base_ff < CNT_BITS'(MAX_ENTRIES - 1);
   assign pend_full  = pend_cnt_ff == CNT_BITS'(MAX_ENTRIES);
   assign read_ok    = 32'(req_data.read_index) < 32'(count);
   assign scan_hit   = {1'b0, pend_rd_data.n} == real_ff.s;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign scan_done  = idx_ff >= pend_cnt_ff;
   assign idx_next   = idx_ff + CNT_BITS'(1);
   assign shift_done = idx_next >= pend_cnt_ff;
   assign req_ent    = '{m: req_data.master_id[ID_BITS-1:0],
                         n: req_data.node_id[ID_BITS-1:0],
                         s: req_data.slave_id[ID_BITS-1:0]};
   assign leaf_ent   = '{m: {1'b0, real_ff.n}, n: real_ff.s[ID_BITS-1:0], s: ID_NONE};

   always_comb begin
      if (status_ff == STAT_READ_OK) begin
         show = show_leaf_ff ? leaf_ent : chain_rd_data;
      end else if (count != '0) begin
         show = leaf_ff ? leaf_ent : real_ff;
      end else begin
         show = '0;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_FINISH;
               case (req_data.opcode)
                  OP_REPORT: begin
                     if (!neg_field) begin
                        if (req_data.master_id == '0) begin
                           if (room2) state_in = S_ROOT_WR;
                        end else if (links_hit) begin
                           if (room1) state_in = S_SCAN_RD;
                        end
                     end
                  end
                  OP_INIT: begin
                     if (!req_data.node_id[7] && !req_data.slave_id[7]) state_in = S_SCAN_RD;
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_ROOT_WR:  state_in = S_SCAN_RD;
         S_SCAN_RD:  state_in = scan_done ? S_FINISH : S_SCAN_CMP;
         S_SCAN_CMP: begin
            if (scan_hit) begin
               state_in = room1 ? S_SHIFT_RD : S_FINISH;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: state_in = scan_done ? S_SCAN_RD : S_SHIFT_WR;
         S_SHIFT_WR: state_in = S_SHIFT_RD;
         S_FINISH:   state_in = out_free ? S_IDLE : S_FINISH;
         default:    state_in = S_IDLE;
      endcase
   end

   // Datapath, memory requests and result beat.
   always_comb begin
      base_in      = base_ff;
      leaf_in      = leaf_ff;
      real_in      = real_ff;
      pend_cnt_in  = pend_cnt_ff;
      idx_in       = idx_ff;
      status_in    = status_ff;
      show_leaf_in = show_leaf_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      chain_wr     = '0;
      chain_rd     = '0;
      pend_wr      = '0;
      pend_rd      = '0;
      req_stall    = state_ff != S_IDLE;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in = STAT_INVALID;
               idx_in    = '0;
               case (req_data.opcode)
                  OP_REPORT: begin
                     if (!neg_field) begin
                        if (req_data.master_id == '0) begin
                           if (room2) begin
                              // Root entry first; the report follows next cycle.
                              chain_wr.en   = 1'b1;
                              chain_wr.addr = base_ff[ADDR_BITS-1:0];
                              chain_wr.data = '{m: ID_NONE, n: root_id, s: req_data.node_id};
                              real_in       = chain_wr.data;
                              base_in       = base_ff + CNT_BITS'(1);
                              leaf_in       = 1'b0;
                              hold_in       = req_ent;
                              status_in     = STAT_CHAINED;
                           end else begin
                              status_in = STAT_FULL;
                           end
                        end else if (links_hit) begin
                           if (room1) begin
                              chain_wr.en   = 1'b1;
                              chain_wr.addr = base_ff[ADDR_BITS-1:0];
                              chain_wr.data = '{m: req_data.master_id,
                                                n: req_data.node_id[ID_BITS-1:0],
                                                s: req_data.slave_id};
                              real_in       = chain_wr.data;
                              base_in       = base_ff + CNT_BITS'(1);
                              leaf_in       = 1'b0;
                              status_in     = STAT_CHAINED;
                           end else begin
                              status_in = STAT_FULL;
                           end
                        end else if (!pend_full) begin
                           pend_wr.en   = 1'b1;
                           pend_wr.addr = pend_cnt_ff[ADDR_BITS-1:0];
                           pend_wr.data = req_ent;
                           pend_cnt_in  = pend_cnt_ff + CNT_BITS'(1);
                           status_in    = STAT_BUFFERED;
                        end else begin
                           status_in = STAT_FULL;
                        end
                     end
                  end
                  OP_INIT: begin
                     if (!req_data.node_id[7] && !req_data.slave_id[7]) begin
                        chain_wr.en   = 1'b1;
                        chain_wr.addr = '0;
                        chain_wr.data = '{m: ID_NONE, n: req_data.node_id[ID_BITS-1:0],
                                          s: req_data.slave_id};
                        real_in       = chain_wr.data;
                        base_in       = CNT_BITS'(1);
                        leaf_in       = 1'b0;
                        status_in     = STAT_CHAINED;
                     end
                  end
                  OP_READ: begin
                     if (read_ok) begin
                        chain_rd.en   = 1'b1;
                        chain_rd.addr = ADDR_BITS'(req_data.read_index);
                        show_leaf_in  = leaf_ff &&
                                        (32'(req_data.read_index) == 32'(base_ff));
                        status_in     = STAT_READ_OK;
                     end else begin
                        status_in = STAT_READ_RANGE;
                     end
                  end
                  default: status_in = STAT_INVALID;
               endcase
            end
         end
         S_ROOT_WR: begin
            chain_wr.en   = 1'b1;
            chain_wr.addr = base_ff[ADDR_BITS-1:0];
            chain_wr.data = '{m: {1'b0, hold_ff.m}, n: hold_ff.n, s: {1'b0, hold_ff.s}};
            real_in       = chain_wr.data;
            base_in       = base_ff + CNT_BITS'(1);
         end
         S_SCAN_RD: begin
            if (scan_done) begin
               // Nothing more links: close the chain if the buffer is empty and room is left.
               if (pend_cnt_ff == '0 && room1) leaf_in = 1'b1;
            end else begin
               pend_rd.en   = 1'b1;
               pend_rd.addr = idx_ff[ADDR_BITS-1:0];
            end
         end
         S_SCAN_CMP: begin
            if (scan_hit) begin
               if (room1) begin
                  chain_wr.en   = 1'b1;
                  chain_wr.addr = base_ff[ADDR_BITS-1:0];
                  chain_wr.data = '{m: {1'b0, pend_rd_data.m}, n: pend_rd_data.n,
                                    s: {1'b0, pend_rd_data.s}};
                  real_in       = chain_wr.data;
                  base_in       = base_ff + CNT_BITS'(1);
                  pend_cnt_in   = pend_cnt_ff - CNT_BITS'(1);
               end
            end else begin
               idx_in = idx_next;
            end
         end
         S_SHIFT_RD: begin
            // pend_cnt_ff no longer counts the removed entry, so entries up to index
            // pend_cnt_ff move down by one place.
            if (scan_done) begin
               idx_in = '0;
            end else begin
               pend_rd.en   = 1'b1;
               pend_rd.addr = idx_next[ADDR_BITS-1:0];
            end
         end
         S_SHIFT_WR: begin
            pend_wr.en   = 1'b1;
            pend_wr.addr = idx_ff[ADDR_BITS-1:0];
            pend_wr.data = pend_rd_data;
            idx_in       = idx_next;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.status          = status_ff;
               rsp_data_in.chain_length    = count;
               rsp_data_in.buffered_count  = pend_cnt_ff;
               rsp_data_in.leaf_present    = leaf_ff;
               rsp_data_in.entry_master    = show.m;
               rsp_data_in.entry_node      = show.n;
               rsp_data_in.entry_slave     = show.s;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= '0;
         leaf_ff      <= 1'b0;
         pend_cnt_ff  <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         leaf_ff      <= leaf_in;
         pend_cnt_ff  <= pend_cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      real_ff      <= real_in;
      status_ff    <= status_in;
      show_leaf_ff <= show_leaf_in;
      hold_ff      <= hold_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_chain_bound: assert property (@(posedge clock) disable iff (reset)
      32'(base_ff) + 32'(leaf_ff) <= MAX_ENTRIES)
      else $error("chain holds more entries than the store");

   a_leaf_needs_entry: assert property (@(posedge clock) disable iff (reset)
      leaf_ff |-> base_ff != '0)
      else $error("closing leaf without a real entry before it");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pend_cnt_ff) <= MAX_ENTRIES)
      else $error("side buffer count beyond its depth");

   a_leaf_only_empty_buffer: assert property (@(posedge clock) disable iff (reset)
      $rose(leaf_ff) |-> pend_cnt_ff == '0)
      else $error("leaf added while reports are still buffered");

   a_result_on_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && out_free) |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("finished beat not moved to the output register");

endmodule

>>> rtl/node_chain_reorder_assembler.sv
`timescale 1ns / 1ps
// Top level of the node chain reorder assembler: register port, sequencer
// and the chain and side-buffer RAMs. Depends on nca_pkg and all nca_ modules.
//
// One beat is taken at a time. A read, a rejected report, a dropped report or
// a report parked in the side buffer goes through decode and then result.
// A report or init that extends the chain then rescans the side buffer, which
// lives in a single-port-read RAM: each buffered entry examined is read and
// then compared, each successful link writes the entry to the chain and moves
// the later entries down one place to close the gap, and every pass restarts
// from the first entry. A report from the root's direct slave first writes the
// root entry. No clearing pass is needed after reset. The result beat sits in
// an output register, and a new beat is accepted while it waits to be taken.
module node_chain_reorder_assembler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  nca_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output nca_pkg::rsp_type                    rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [nca_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import nca_pkg::*;

   logic [ID_BITS-1:0] root_ff, root_in;
   logic               csr_wr;
   logic               csr_hit;

   chain_wr_type  chain_wr;
   mem_rd_type    chain_rd;
   chain_ent_type chain_rd_data;
   pend_wr_type   pend_wr;
   mem_rd_type    pend_rd;
   pend_ent_type  pend_rd_data;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[CSR_ADDR_BITS-1] == CSR_IDX_ROOT;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign root_in    = (csr_wr && csr_hit) ? csr_pwdata[ID_BITS-1:0] : root_ff;
   assign csr_prdata = csr_hit ? 32'(root_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
      end else begin
         root_ff <= root_in;
      end
   end

   nca_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .root_id       (root_ff),
      .chain_wr      (chain_wr),
      .chain_rd      (chain_rd),
      .chain_rd_data (chain_rd_data),
      .pend_wr       (pend_wr),
      .pend_rd       (pend_rd),
      .pend_rd_data  (pend_rd_data)
   );

   nca_chain_ram u_chain_ram (
      .clock   (clock),
      .wr      (chain_wr),
      .rd      (chain_rd),
      .rd_data (chain_rd_data)
   );

   nca_pend_ram u_pend_ram (
      .clock   (clock),
      .wr      (pend_wr),
      .rd      (pend_rd),
      .rd_data (pend_rd_data)
   );

endmodule
